// ===== rtl/core/sidt_pkg.sv =====
`default_nettype none

package sidt_pkg;

    localparam int CAPACITY = 65536;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int ID_W     = 63;
    localparam int SIZE_W   = 31;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 16;

    localparam int S_FIELDS_W = ID_W + ID_W + SIZE_W + 1;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = POS_W + ID_W + SIZE_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTINCR  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   container;
        logic [SIZE_W-1:0] object_size;
        logic              is_file;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [ID_W-1:0]   found_container;
        logic [SIZE_W-1:0] found_size;
        logic              found_is_dir;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   container;
        logic [SIZE_W-1:0] object_size;
        logic              is_dir;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/sidt_engine.sv =====
`default_nettype none

module sidt_engine
    import sidt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic req_valid,
    input  wire req_t req,
    output logic      req_ready,
    output logic      rsp_valid,
    output rsp_t      rsp,
    input  wire logic rsp_take
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  last_id_reg, last_id_next;
    logic [ID_W-1:0]  key_reg, key_next;
    rsp_t             rsp_reg, rsp_next;

    entry_t           rec_mem [CAPACITY];
    entry_t           rd_data_reg;
    entry_t           wr_data;
    logic             wr_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W:0]   cur_sum;
    logic [CNT_W-1:0] cur_mid;
    logic [CNT_W:0]   nxt_sum;
    logic             start;
    logic             found;

    assign start     = req_valid && (state_reg == ST_IDLE);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    assign cur_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign cur_mid = cur_sum[CNT_W:1];
    assign nxt_sum = {1'b0, lo_next} + {1'b0, hi_next};
    assign rd_addr = nxt_sum[ADDR_W:1];

    assign found = (lo_reg < count_reg) && (rd_data_reg.id == key_reg);

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        count_next   = count_reg;
        last_id_next = last_id_reg;
        key_next     = key_reg;
        rsp_next     = rsp_reg;
        wr_en        = 1'b0;
        wr_data.id          = req.id;
        wr_data.container   = req.container;
        wr_data.object_size = req.object_size;
        wr_data.is_dir      = ~req.is_file;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rsp_next   = '0;
                    state_next = ST_DONE;
                    case (req.op)
                        OP_ADD: begin
                            if (req.id <= last_id_reg) begin
                                rsp_next.status = STAT_NOTINCR;
                            end else if (count_reg[CNT_W-1]) begin
                                rsp_next.status = STAT_FULL;
                            end else begin
                                wr_en             = 1'b1;
                                rsp_next.position = POS_W'(count_reg);
                                count_next        = count_reg + 1'b1;
                                last_id_next      = req.id;
                            end
                        end
                        OP_LOOKUP: begin
                            key_next   = req.id;
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = ST_SEARCH;
                        end
                        OP_CLEAR: begin
                            count_next   = '0;
                            last_id_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    if (rd_data_reg.id < key_reg) begin
                        lo_next = cur_mid + 1'b1;
                    end else begin
                        hi_next = cur_mid;
                    end
                end else begin
                    state_next = ST_DONE;
                    if (found) begin
                        rsp_next.status          = STAT_OK;
                        rsp_next.position        = POS_W'(lo_reg);
                        rsp_next.found_container = rd_data_reg.container;
                        rsp_next.found_size      = rd_data_reg.object_size;
                        rsp_next.found_is_dir    = rd_data_reg.is_dir;
                    end else begin
                        rsp_next        = '0;
                        rsp_next.status = STAT_NOTFOUND;
                    end
                end
            end
            ST_DONE: begin
                if (rsp_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= rec_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            last_id_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            last_id_reg <= last_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_id_table_search.sv =====
// Add, clear and unused op results pass the engine response register, then the output register.
// Lookup runs a binary search over the entry count, with one registered record-memory read
// per probe plus the final read at the landing index, before its result takes the same path.
// Only one item is handled at a time; the next beat is accepted once a result has moved into
// the output register, while that result may still wait for m_axis_tready.
// Reset (aresetn low, synchronous) empties the table.
`default_nettype none

module sorted_id_table_search
    import sidt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // id, container, object_size, is_file, zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  wire logic [OP_W-1:0]      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // position, found_container, found_size, found_is_dir, zero pad
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [STAT_W-1:0]         m_axis_tuser
);

    req_t req;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_take;
    logic out_free;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [STAT_W-1:0]    m_user_reg;

    assign req.op          = s_axis_tuser;
    assign req.id          = s_axis_tdata[ID_W-1:0];
    assign req.container   = s_axis_tdata[2*ID_W-1:ID_W];
    assign req.object_size = s_axis_tdata[2*ID_W+SIZE_W-1:2*ID_W];
    assign req.is_file     = s_axis_tdata[2*ID_W+SIZE_W];

    assign out_free = !m_valid_reg || m_axis_tready;
    assign rsp_take = rsp_valid && out_free;

    sidt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req       (req),
        .req_ready (s_axis_tready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_take  (rsp_take)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_take) begin
            m_data_reg <= M_TDATA_W'({rsp.found_is_dir, rsp.found_size,
                                      rsp.found_container, rsp.position});
            m_user_reg <= rsp.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire
